// ===== hdl/bnr_pkg.sv =====
package bnr_pkg;

  // field widths of the stream items and registers
  localparam int ROW_W  = 9;
  localparam int COL_W  = 9;
  localparam int DATA_W = 32;
  localparam int GAIN_W = 17;
  localparam int CFG_W  = 9;
  localparam int FRAC_W = 16;

  // internal widths, sized for grids up to 4096 on a side
  localparam int DIFF_W = 13;              // signed distance along one axis
  localparam int SQ_W   = 23;              // one squared axis distance
  localparam int DIST_W = 24;              // squared distance to one notch
  localparam int P_W    = 2 * DIST_W;      // product of both squared distances
  localparam int R2_W   = 2 * CFG_W;       // radius squared
  localparam int R4_W   = 2 * R2_W;        // radius to the fourth
  localparam int SUM_W  = P_W + 1;         // divisor p + r^4

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_W;

  // register reset values
  localparam logic [CFG_W-1:0]        CUTOFF_RST  = 9'd50;
  localparam logic signed [CFG_W-1:0] ROW_OFS_RST = 9'sd16;
  localparam logic signed [CFG_W-1:0] COL_OFS_RST = 9'sd81;

  // register indexes
  typedef enum logic [1:0] {
    CFG_CUTOFF  = 2'd0,
    CFG_ROW_OFS = 2'd1,
    CFG_COL_OFS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0]        cutoff;
    logic signed [CFG_W-1:0] row_ofs;
    logic signed [CFG_W-1:0] col_ofs;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } bin_t;

  // distance stage to divider
  typedef struct packed {
    logic [P_W-1:0]           p;
    logic [SUM_W-1:0]         sden;
    logic                     zero;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } quot_req_t;

  // divider to scaler
  typedef struct packed {
    logic [GAIN_W-1:0]        gain;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } gain_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_real;
    logic signed [DATA_W-1:0] out_imag;
    logic [GAIN_W-1:0]        gain;
  } res_t;

endpackage

// ===== hdl/bnr_dist.sv =====
module bnr_dist #(
  parameter int GRID_ROWS = 512,
  parameter int GRID_COLS = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  bnr_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  bnr_pkg::bin_t      in_bin,
  output logic               out_valid,
  input  logic               out_ready,
  output bnr_pkg::quot_req_t out_req
);
  import bnr_pkg::*;

  localparam int NST = 5;
  localparam logic signed [DIFF_W-1:0] ROW_CTR = DIFF_W'(GRID_ROWS / 2);
  localparam logic signed [DIFF_W-1:0] COL_CTR = DIFF_W'(GRID_COLS / 2);

  logic [NST-1:0] v;
  logic [NST-1:0] adv;

  logic signed [DIFF_W-1:0] r, c, ru, cv;
  logic signed [DIFF_W-1:0] a1, b1, a2, b2;
  logic signed [2*DIFF_W-1:0] m_a1, m_b1, m_a2, m_b2;
  logic [SQ_W-1:0]   sq_a1, sq_b1, sq_a2, sq_b2;
  logic [DIST_W-1:0] d1, d2;
  logic [P_W-1:0]    p;
  logic [R2_W-1:0]   r2;
  logic [R4_W-1:0]   r4;
  logic signed [DATA_W-1:0] re_q [NST-1];
  logic signed [DATA_W-1:0] im_q [NST-1];
  quot_req_t req;

  // bubble-collapsing stage enables
  always_comb begin
    adv[NST-1] = !v[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  // radius to the fourth, follows the register
  always_ff @(posedge clk) begin
    r2 <= cfg.cutoff * cfg.cutoff;
    r4 <= r2 * r2;
  end

  // offsets from the grid center
  assign r  = $signed(DIFF_W'(in_bin.row)) - ROW_CTR;
  assign c  = $signed(DIFF_W'(in_bin.col)) - COL_CTR;
  assign ru = $signed({{(DIFF_W-CFG_W){cfg.row_ofs[CFG_W-1]}}, cfg.row_ofs});
  assign cv = $signed({{(DIFF_W-CFG_W){cfg.col_ofs[CFG_W-1]}}, cfg.col_ofs});

  assign m_a1 = a1 * a1;
  assign m_b1 = b1 * b1;
  assign m_a2 = a2 * a2;
  assign m_b2 = b2 * b2;

  // stage 0: axis distances to both notch centers
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a1 <= r - ru;
      b1 <= c - cv;
      a2 <= r + ru;
      b2 <= c + cv;
      re_q[0] <= in_bin.re;
      im_q[0] <= in_bin.im;
    end
  end

  // stage 1: squares
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sq_a1 <= m_a1[SQ_W-1:0];
      sq_b1 <= m_b1[SQ_W-1:0];
      sq_a2 <= m_a2[SQ_W-1:0];
      sq_b2 <= m_b2[SQ_W-1:0];
      re_q[1] <= re_q[0];
      im_q[1] <= im_q[0];
    end
  end

  // stage 2: squared distances
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      d1 <= DIST_W'(sq_a1) + DIST_W'(sq_b1);
      d2 <= DIST_W'(sq_a2) + DIST_W'(sq_b2);
      re_q[2] <= re_q[1];
      im_q[2] <= im_q[1];
    end
  end

  // stage 3: product of both distances
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      p <= d1 * d2;
      re_q[3] <= re_q[2];
      im_q[3] <= im_q[2];
    end
  end

  // stage 4: divisor and on-notch flag
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      req.p    <= p;
      req.sden <= SUM_W'(p) + SUM_W'(r4);
      req.zero <= (p == '0);
      req.re   <= re_q[3];
      req.im   <= im_q[3];
    end
  end

  assign out_valid = v[NST-1];
  assign out_req   = req;

endmodule

// ===== hdl/bnr_div.sv =====
module bnr_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bnr_pkg::quot_req_t in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output bnr_pkg::gain_req_t out_req
);
  import bnr_pkg::*;

  localparam int NST = GAIN_W;

  typedef struct packed {
    logic [SUM_W-1:0]         rem;
    logic [SUM_W-1:0]         sden;
    logic [GAIN_W-1:0]        q;
    logic                     zero;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } div_st_t;

  logic [NST-1:0] v;
  logic [NST-1:0] adv;
  div_st_t st  [NST];
  div_st_t src [NST];
  div_st_t nxt [NST];

  // bubble-collapsing stage enables
  always_comb begin
    adv[NST-1] = !v[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  // stage sources: the request, then the previous stage
  always_comb begin
    src[0].rem  = SUM_W'(in_req.p);
    src[0].sden = in_req.sden;
    src[0].q    = '0;
    src[0].zero = in_req.zero;
    src[0].re   = in_req.re;
    src[0].im   = in_req.im;
    for (int k = 1; k < NST; k++) begin
      src[k] = st[k-1];
    end
  end

  // one restoring quotient bit per stage, msb first
  always_comb begin
    logic [SUM_W:0] trial;
    logic [SUM_W:0] diff;
    logic           ge;
    for (int k = 0; k < NST; k++) begin
      trial = (k == 0) ? {1'b0, src[k].rem} : {src[k].rem, 1'b0};
      diff  = trial - {1'b0, src[k].sden};
      ge    = (trial >= {1'b0, src[k].sden});
      nxt[k]   = src[k];
      nxt[k].q = {src[k].q[GAIN_W-2:0], ge};
      if (ge) begin
        nxt[k].rem = diff[SUM_W-1:0];
      end else begin
        nxt[k].rem = trial[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (adv[k]) st[k] <= nxt[k];
    end
  end

  // a bin on a notch center gets no gain
  assign out_valid    = v[NST-1];
  assign out_req.gain = st[NST-1].zero ? '0 : st[NST-1].q;
  assign out_req.re   = st[NST-1].re;
  assign out_req.im   = st[NST-1].im;

  // remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (v[NST-1] && !st[NST-1].zero) |-> (st[NST-1].rem < st[NST-1].sden))
    else $error("divider remainder not below divisor");

  // gain never exceeds one
  a_gain_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_req.gain <= GAIN_ONE))
    else $error("gain above one");

endmodule

// ===== hdl/bnr_scale.sv =====
module bnr_scale (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bnr_pkg::gain_req_t in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output bnr_pkg::res_t      out_res
);
  import bnr_pkg::*;

  localparam int NST  = 2;
  localparam int PR_W = DATA_W + GAIN_W + 1;

  logic [NST-1:0] v;
  logic [NST-1:0] adv;
  logic signed [GAIN_W:0]   g_s;
  logic signed [PR_W-1:0]   prod_re, prod_im;
  logic [GAIN_W-1:0]        gain_q;
  res_t                     res;

  always_comb begin
    adv[NST-1] = !v[NST-1] || out_ready;
    adv[0]     = !v[0] || adv[1];
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      if (adv[1]) v[1] <= v[0];
    end
  end

  assign g_s = $signed({1'b0, in_req.gain});

  // stage 0: full products
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      prod_re <= in_req.re * g_s;
      prod_im <= in_req.im * g_s;
      gain_q  <= in_req.gain;
    end
  end

  // stage 1: drop the fraction, rounding toward minus infinity
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      res.out_real <= prod_re[FRAC_W +: DATA_W];
      res.out_imag <= prod_im[FRAC_W +: DATA_W];
      res.gain     <= gain_q;
    end
  end

  assign out_valid = v[NST-1];
  assign out_res   = res;

endmodule

// ===== hdl/butterworth_notch_reject_bin_unit.sv =====
// Butterworth notch-reject gain, order 2, for one centered spectrum bin.
// Input stream s_*: one bin per request (row, column, complex value).
// Output stream m_*: the bin scaled by the notch gain, plus the gain itself.
// Config channel cfg_*: index 0 cutoff radius, 1 row offset, 2 column offset;
// always ready, write only while no bin is in flight.
// From input accept to m_tvalid a bin passes 5 distance stages,
// 17 divider stages (one quotient bit each) and 2 scaling stages.
// Throughput is one bin per cycle while m_tready stays high; the 17-stage restoring divider and the
// 24x24 distance product are the deepest parts and set the stage count.
// Every stage holds its own valid bit, so empty stages fill while
// m_tready is low and s_tready drops only once all stages hold a bin.
// s_tready is high whenever no result is pending at the output.
// Reset clears all valid bits and loads the register reset values
// (radius 50, row offset 16, column offset 81); the radius feeds two
// product registers, r2 and then r4, that settle after a write.
module butterworth_notch_reject_bin_unit #(
  parameter int GRID_ROWS = 512,
  parameter int GRID_COLS = 512
) (
  input  logic        clk,
  input  logic        rst,
  // fields from bit 0: bin_row[8:0], bin_col[8:0], bin_real[31:0], bin_imag[31:0], pad
  input  logic [87:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // fields from bit 0: out_real[31:0], out_imag[31:0], gain[16:0], pad
  output logic [87:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import bnr_pkg::*;

  localparam int OUT_W = 2 * DATA_W + GAIN_W;

  cfg_t      cfg;
  bin_t      in_bin;
  quot_req_t q_req;
  gain_req_t g_req;
  res_t      res;
  logic      q_valid, q_ready;
  logic      g_valid, g_ready;

  // register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cutoff  <= CUTOFF_RST;
      cfg.row_ofs <= ROW_OFS_RST;
      cfg.col_ofs <= COL_OFS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CUTOFF:  cfg.cutoff  <= cfg_data;
        CFG_ROW_OFS: cfg.row_ofs <= $signed(cfg_data);
        CFG_COL_OFS: cfg.col_ofs <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // unpack the input bin
  assign in_bin.row = s_tdata[ROW_W-1:0];
  assign in_bin.col = s_tdata[ROW_W +: COL_W];
  assign in_bin.re  = $signed(s_tdata[ROW_W+COL_W +: DATA_W]);
  assign in_bin.im  = $signed(s_tdata[ROW_W+COL_W+DATA_W +: DATA_W]);

  bnr_dist #(
    .GRID_ROWS(GRID_ROWS),
    .GRID_COLS(GRID_COLS)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_bin   (in_bin),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_req  (q_req)
  );

  bnr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_ready (q_ready),
    .in_req   (q_req),
    .out_valid(g_valid),
    .out_ready(g_ready),
    .out_req  (g_req)
  );

  bnr_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (g_valid),
    .in_ready (g_ready),
    .in_req   (g_req),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_res  (res)
  );

  // pack the result
  assign m_tdata = {{(88-OUT_W){1'b0}}, res.gain, res.out_imag, res.out_real};

  // no result right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // an empty output stage always takes a new bin
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

// ===== tb/bnr_checker.sv =====
module bnr_checker #(
  parameter int GRID_ROWS = 512,
  parameter int GRID_COLS = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [87:0] s_tdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [87:0] m_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output int          mismatches,
  output int          scaled_due
);
  import bnr_pkg::*;

  // shadow copy of the notch registers
  logic [CFG_W-1:0]        radius;
  logic signed [CFG_W-1:0] row_ofs;
  logic signed [CFG_W-1:0] col_ofs;

  // scaled bins still owed by the block, oldest first
  res_t scaled_q[$];
  int   fail_n;

  // exact notch gain and truncated scaling of one bin
  function automatic res_t notch_scale(input logic [ROW_W-1:0] row,
                                       input logic [COL_W-1:0] col,
                                       input logic signed [DATA_W-1:0] re,
                                       input logic signed [DATA_W-1:0] im);
    longint dr, dc, a1, b1, a2, b2, gs;
    longint unsigned d1, d2, p, r2, r4, g;
    res_t res;
    dr = longint'(row) - GRID_ROWS / 2;
    dc = longint'(col) - GRID_COLS / 2;
    a1 = dr - longint'(row_ofs);
    b1 = dc - longint'(col_ofs);
    a2 = dr + longint'(row_ofs);
    b2 = dc + longint'(col_ofs);
    d1 = a1 * a1 + b1 * b1;
    d2 = a2 * a2 + b2 * b2;
    p  = d1 * d2;
    r2 = longint'(radius) * longint'(radius);
    r4 = r2 * r2;
    // on a notch center the bin is removed outright
    g  = (p == 0) ? 0 : (p << FRAC_W) / (p + r4);
    gs = g;
    res.gain     = g[GAIN_W-1:0];
    res.out_real = DATA_W'((longint'(re) * gs) >>> FRAC_W);
    res.out_imag = DATA_W'((longint'(im) * gs) >>> FRAC_W);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    res_t got;
    if (rst) begin
      radius  = CUTOFF_RST;
      row_ofs = ROW_OFS_RST;
      col_ofs = COL_OFS_RST;
      scaled_q.delete();
      fail_n  = 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CUTOFF:  radius  = cfg_data;
          CFG_ROW_OFS: row_ofs = cfg_data;
          CFG_COL_OFS: col_ofs = cfg_data;
          default: ;
        endcase
      end
      // output request against the oldest expectation
      if (m_tvalid && m_tready) begin
        got.out_real = m_tdata[31:0];
        got.out_imag = m_tdata[63:32];
        got.gain     = m_tdata[80:64];
        if (scaled_q.size() == 0) begin
          $error("unexpected result: out_real %0d out_imag %0d gain %0d",
                 got.out_real, got.out_imag, got.gain);
          fail_n++;
        end else begin
          want = scaled_q.pop_front();
          if (got.out_real !== want.out_real) begin
            $error("out_real: expected %0d, actual %0d", want.out_real, got.out_real);
            fail_n++;
          end
          if (got.out_imag !== want.out_imag) begin
            $error("out_imag: expected %0d, actual %0d", want.out_imag, got.out_imag);
            fail_n++;
          end
          if (got.gain !== want.gain) begin
            $error("gain: expected %0d, actual %0d", want.gain, got.gain);
            fail_n++;
          end
        end
      end
      // input request
      if (s_tvalid && s_tready)
        scaled_q.push_back(notch_scale(s_tdata[8:0], s_tdata[17:9],
                                       s_tdata[49:18], s_tdata[81:50]));
    end
    scaled_due <= scaled_q.size();
    mismatches <= fail_n;
  end

endmodule

// ===== tb/tb_butterworth_notch_reject_bin_unit.sv =====
module tb_butterworth_notch_reject_bin_unit;
  import bnr_pkg::*;

  localparam int GRID_ROWS     = 512;
  localparam int GRID_COLS     = 512;
  localparam int N_PHASES      = 6;
  localparam int BINS_PER_SET  = 130;
  localparam int HOLD_CYCLES   = 100;
  localparam int DRAIN_WAIT    = 40;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 200000;

  logic        clk;
  logic        rst;
  // fields from bit 0: bin_row[8:0], bin_col[8:0], bin_real[31:0], bin_imag[31:0], pad
  logic [87:0] s_tdata;
  logic        s_tvalid;
  logic        s_tready;
  // fields from bit 0: out_real[31:0], out_imag[31:0], gain[16:0], pad
  logic [87:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  int mismatches;
  int scaled_due;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  // current notch setting, used to aim bins near the centers
  logic [8:0]        cur_radius  = CUTOFF_RST;
  logic signed [8:0] cur_row_ofs = ROW_OFS_RST;
  logic signed [8:0] cur_col_ofs = COL_OFS_RST;

  butterworth_notch_reject_bin_unit #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bnr_checker #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tdata    (s_tdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tdata    (m_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .scaled_due (scaled_due)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("butterworth_notch_reject_bin_unit regression: fail");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : sink
    int idle_left;
    int hold_left;
    idle_left = 0;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (idle_left > 0) begin
        m_tready <= 1'b0;
        idle_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        idle_left = $urandom_range(1, 5) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // offer one bin and hold it until accepted
  task automatic send_bin(input logic [8:0] row, input logic [8:0] col,
                          input logic [31:0] re, input logic [31:0] im);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tdata  <= {6'd0, im, re, col, row};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // random value, now and then an extreme, zero or minus one
  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // random bin: anywhere on the grid, or close to one of the two notch centers
  task automatic send_random_bin();
    logic [8:0] row;
    logic [8:0] col;
    int span;
    int dr;
    int dc;
    if ($urandom_range(0, 9) < 4) begin
      row = 9'($urandom);
      col = 9'($urandom);
    end else begin
      span = $urandom_range(1, int'(cur_radius) + 3);
      dr = int'($urandom_range(0, 2 * span)) - span;
      dc = int'($urandom_range(0, 2 * span)) - span;
      if ($urandom_range(0, 1) == 1) begin
        row = 9'(GRID_ROWS / 2 + int'(cur_row_ofs) + dr);
        col = 9'(GRID_COLS / 2 + int'(cur_col_ofs) + dc);
      end else begin
        row = 9'(GRID_ROWS / 2 - int'(cur_row_ofs) + dr);
        col = 9'(GRID_COLS / 2 - int'(cur_col_ofs) + dc);
      end
    end
    send_bin(row, col, pick_sample(), pick_sample());
  endtask

  // stop offering and wait until every result is back and the block is quiet
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (scaled_due != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // new notch setting, written while the block is idle
  task automatic load_setting(input logic [8:0] rad, input logic [8:0] rofs,
                              input logic [8:0] cofs);
    drain();
    write_reg(CFG_CUTOFF, rad);
    write_reg(CFG_ROW_OFS, rofs);
    write_reg(CFG_COL_OFS, cofs);
    cfg_valid <= 1'b0;
    // radius products settle after the write
    repeat (SETTLE_CYCLES) @(posedge clk);
    cur_radius  = rad;
    cur_row_ofs = rofs;
    cur_col_ofs = cofs;
  endtask

  // stimulus
  initial begin
    rst       <= 1'b1;
    s_tdata   <= '0;
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_CUTOFF;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        1: load_setting(9'd0, 9'd0, 9'd0);
        2: load_setting(9'd511, 9'h100, 9'd255);
        3: load_setting(9'd1, 9'd255, 9'h100);
        4: load_setting(9'($urandom_range(0, 64)), 9'($urandom), 9'($urandom));
        5: load_setting(9'($urandom), 9'($urandom), 9'($urandom));
        default: ;
      endcase
      // no idling in the last part
      calm = (ph == N_PHASES - 1);

      case (ph)
        0: begin
          // grid corners with full-scale values
          send_bin(9'd0, 9'd0, 32'h7fff_ffff, 32'h8000_0000);
          send_bin(9'd511, 9'd511, 32'h8000_0000, 32'h7fff_ffff);
          // both notch centers remove the bin; then one bin at the grid center
          send_bin(9'd272, 9'd337, 32'd12345, -32'sd777);
          send_bin(9'd240, 9'd175, 32'hffff_ffff, 32'd1);
          send_bin(9'd256, 9'd256, 32'hffff_ffff, -32'sd65536);
          // just off a center: small gain, negative values round down; then three bins off the notches
          send_bin(9'd272, 9'd338, 32'h7fff_ffff, 32'h8000_0000);
          send_bin(9'h155, 9'h0aa, 32'h5555_5555, 32'haaaa_aaaa);
          send_bin(9'h0aa, 9'h155, 32'haaaa_aaaa, 32'h5555_5555);
          send_bin(9'd300, 9'd300, 32'd1, 32'hffff_ffff);
        end
        1: begin
          // zero radius: center still removed, anything else passes unchanged
          send_bin(9'd256, 9'd256, 32'h7fff_ffff, 32'h8000_0000);
          send_bin(9'd0, 9'd0, 32'h8000_0000, 32'h7fff_ffff);
          send_bin(9'd257, 9'd256, 32'hffff_ffff, 32'h8000_0000);
        end
        2: begin
          // widest radius, offsets at the extremes
          send_bin(9'd0, 9'd511, 32'h7fff_ffff, 32'h8000_0000);
          send_bin(9'd511, 9'd1, 32'h8000_0000, 32'hffff_ffff);
          send_bin(9'd256, 9'd256, 32'h7fff_ffff, 32'h0000_0001);
        end
        3: begin
          send_bin(9'd511, 9'd0, 32'h7fff_ffff, 32'h8000_0000);
          send_bin(9'd1, 9'd511, 32'h8000_0000, 32'h7fff_ffff);
        end
        default: ;
      endcase

      for (int k = 0; k < BINS_PER_SET; k++) begin
        // long result-side hold-off while bins keep coming
        if (ph == 2 && k == 40)
          hold_req = 1'b1;
        send_random_bin();
      end
    end

    drain();
    if (mismatches == 0)
      $display("butterworth_notch_reject_bin_unit regression: pass");
    else
      $display("butterworth_notch_reject_bin_unit regression: fail");
    $finish;
  end

endmodule
